// File: rtl/core/afce_pkg.sv
// ----------------------------------------------------------------------------
// afce_pkg
// Shared types and constants of the ADC frame channel extractor.
// ----------------------------------------------------------------------------
package afce_pkg;

  // Stream word and sample widths
  localparam int unsigned WordW      = 32;
  localparam int unsigned SampleW    = 24;
  localparam int unsigned TagW       = 8;
  localparam int unsigned MaxBytesW  = 12;
  localparam int unsigned CountW     = 10;
  localparam int unsigned LimitW     = 16;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 12;

  // Upper bound on the frame byte count, applied on top of the register
  localparam logic [LimitW-1:0] MaxFrameBytesLimit = 16'd4095;

  // Framing constants
  localparam logic [WordW-1:0] SyncWord    = 32'hFFFF_FFFF;

  // Register reset values
  localparam logic [TagW-1:0]      ChannelTagRst    = 8'hEA;
  localparam logic [MaxBytesW-1:0] MaxFrameBytesRst = 12'd1500;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CHANNEL_TAG     = 1'b0,
    CFG_MAX_FRAME_BYTES = 1'b1
  } cfg_idx_e;

  // Parser phases
  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_COUNT   = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_e;

  // Current register contents
  typedef struct packed {
    logic [TagW-1:0]      channel_tag;
    logic [MaxBytesW-1:0] max_frame_bytes;
  } cfg_t;

  // Parser decision for one item
  typedef struct packed {
    logic               hit;
    logic [SampleW-1:0] sample;
  } parse_res_t;

endpackage

// File: rtl/core/afce_cfg.sv
// ----------------------------------------------------------------------------
// afce_cfg
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module afce_cfg
  import afce_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CHANNEL_TAG:     cfg_d.channel_tag     = cfg_data_i[TagW-1:0];
        CFG_MAX_FRAME_BYTES: cfg_d.max_frame_bytes = cfg_data_i[MaxBytesW-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_tag     <= ChannelTagRst;
      cfg_q.max_frame_bytes <= MaxFrameBytesRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/afce_in_stage.sv
// ----------------------------------------------------------------------------
// afce_in_stage
// Input register: holds one stream word until the parser takes it.
// ----------------------------------------------------------------------------
module afce_in_stage
  import afce_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WordW-1:0] in_word_i,
  input  logic             take_i,
  output logic             valid_o,
  output logic [WordW-1:0] word_o
);

  logic             valid_q, valid_d;
  logic [WordW-1:0] word_q;

  // Accept when empty or when the held item leaves this cycle
  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (take_i)     valid_d = 1'b0;
    if (in_valid_i && in_ready_o) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q <= in_word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// File: rtl/core/afce_parser.sv
// ----------------------------------------------------------------------------
// afce_parser
// Frame parser: tracks sync, header, byte count and payload words and
// picks out payload words whose top byte equals the channel tag.
// ----------------------------------------------------------------------------
module afce_parser
  import afce_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [WordW-1:0] word_i,
  input  cfg_t             cfg_i,
  output parse_res_t       res_o
);

  phase_e              phase_q, phase_d;
  logic [CountW-1:0]   left_q, left_d;
  logic [CountW-1:0]   left_dec;
  logic [LimitW-1:0]   reg_limit;
  logic [LimitW-1:0]   limit;
  logic                too_big;
  logic                no_payload;

  // Effective byte limit is the smaller of register and hard bound
  assign reg_limit  = LimitW'(cfg_i.max_frame_bytes);
  assign limit      = (reg_limit > MaxFrameBytesLimit) ? MaxFrameBytesLimit : reg_limit;
  assign too_big    = word_i > {{(WordW-LimitW){1'b0}}, limit};
  assign no_payload = (word_i[WordW-1:2] == '0);
  assign left_dec   = (left_q != '0) ? left_q - CountW'(1) : left_q;

  // Next state
  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    if (step_i) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (word_i == SyncWord) phase_d = PH_HEADER;
        end
        PH_HEADER: begin
          phase_d = word_i[WordW-1] ? PH_HUNT : PH_COUNT;
        end
        PH_COUNT: begin
          if (too_big || no_payload) begin
            phase_d = PH_HUNT;
            left_d  = '0;
          end else begin
            phase_d = PH_PAYLOAD;
            left_d  = word_i[CountW+1:2];
          end
        end
        PH_PAYLOAD: begin
          left_d = left_dec;
          if (left_dec == '0) phase_d = PH_HUNT;
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  // Outputs: keep payload words carrying the selected tag
  always_comb begin
    res_o.hit    = step_i && (phase_q == PH_PAYLOAD)
                   && (word_i[WordW-1:SampleW] == cfg_i.channel_tag);
    res_o.sample = word_i[SampleW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      left_q  <= '0;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

endmodule

// File: rtl/core/adc_frame_channel_extract.sv
// ----------------------------------------------------------------------------
// adc_frame_channel_extract
// Deframes a stream of ADC frames and emits the samples of one channel.
//
//   channel   dir  tdata bits              tlast/tuser
//   s_axis    in   [31:0] stream_word      none
//   m_axis    out  [23:0] sample (signed)  none
//   cfg       in   idx 0 channel_tag, idx 1 max_frame_bytes
//
// One item per cycle sustained while m_axis accepts; an accepted word sits in
// the input register and its result, if any, is loaded into the result register
// once that register is free, so a result passes through both registers.
// Reset puts the parser into sync hunt and loads the register defaults.
// A stall on m_axis backs up into s_axis after both registers fill.
// ----------------------------------------------------------------------------
module adc_frame_channel_extract
  import afce_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // stream_word [31:0]
  input  logic [WordW-1:0]    s_axis_tdata,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // sample [23:0]
  output logic [SampleW-1:0]  m_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t               cfg;
  logic               in_valid;
  logic [WordW-1:0]   in_word;
  logic               out_free;
  logic               step;
  parse_res_t         res;
  logic               out_valid_q, out_valid_d;
  logic [SampleW-1:0] out_sample_q;

  afce_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  afce_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_word_i  (s_axis_tdata),
    .take_i     (step),
    .valid_o    (in_valid),
    .word_o     (in_word)
  );

  // Advance the held item when the result register can take it
  assign out_free = !out_valid_q || m_axis_tready;
  assign step     = in_valid && out_free;

  afce_parser u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .word_i (in_word),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) out_valid_d = res.hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.hit && out_free) begin
      out_sample_q <= res.sample;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sample_q;

endmodule

// File: rtl/core/afce_checker.sv
// ----------------------------------------------------------------------------
// afce_checker
// Port-level checks of the channel extractor, bound to the top level.
// ----------------------------------------------------------------------------
module afce_checker
  import afce_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [SampleW-1:0]  m_axis_tdata,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // With no result pending the block always takes input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty result register");

  // Filling the input register behind a stalled result ties ready to the sink
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready && s_axis_tvalid && s_axis_tready
    |=> s_axis_tready == m_axis_tready)
    else $error("backpressure not passed upstream");

  // No result straight out of reset
  a_reset_empty: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind adc_frame_channel_extract afce_checker u_afce_checker (.*);
